// ----- hw/rtl/dcld_pkg.sv -----
// Shared types and constants of the discrete command line driver.
// No dependencies; dcld_front, dcld_back and the top level import this package.
package dcld_pkg;

  // Default table sizes
  localparam int CMD_DEPTH_DEF  = 64;
  localparam int PORT_DEPTH_DEF = 16;

  // Queue depths between front, back and the result port
  localparam int REQ_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // Number of codes of the port select field
  localparam int PSEL_VALUES = 16;

  // Input opcodes
  localparam logic [1:0] OPC_LOAD_CMD  = 2'd0;
  localparam logic [1:0] OPC_LOAD_PORT = 2'd1;
  localparam logic [1:0] OPC_EXEC      = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STROBE_MODE   = 2'd0;
  localparam logic [1:0] CFG_COMMAND_COUNT = 2'd1;
  localparam logic [6:0] COMMAND_COUNT_RST = 7'd64;

  // Strobe modes
  localparam logic [1:0] SM_SIGNAL = 2'd0;
  localparam logic [1:0] SM_IO     = 2'd1;

  // Command types
  localparam logic [2:0] CT_STEP   = 3'd0;
  localparam logic [2:0] CT_STRB   = 3'd1;
  localparam logic [2:0] CT_UNSTRB = 3'd2;
  localparam logic [2:0] CT_SET    = 3'd3;
  localparam logic [2:0] CT_SELECT = 3'd4;

  // Status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_RANGE      = 3'd1;
  localparam logic [2:0] STS_MISMATCH   = 3'd2;
  localparam logic [2:0] STS_UNKNOWN    = 3'd3;
  localparam logic [2:0] STS_SKIPPED    = 3'd4;
  localparam logic [2:0] STS_BAD_STROBE = 3'd5;

  // Strobe by I/O write
  localparam logic [11:0] STROBE_IO_ADDR  = 12'h30E;
  localparam logic [15:0] STROBE_CODE_CLR = 16'd2;
  localparam logic [15:0] STROBE_CODE_SET = 16'd3;

  typedef enum logic [1:0] {
    RQ_LOAD_CMD,
    RQ_LOAD_PORT,
    RQ_BAD_OP,
    RQ_EXEC
  } req_cls_t;

  typedef enum logic [1:0] {
    RK_BUS_WRITE,
    RK_STROBE,
    RK_STATUS
  } res_kind_t;

  // Classified request between front and back
  typedef struct packed {
    req_cls_t    cls;
    logic        in_range;
    logic [5:0]  index;
    logic [2:0]  entry_kind;
    logic [3:0]  port_select;
    logic [15:0] bit_mask;
    logic [15:0] data_value;
    logic [11:0] bus_addr;
    logic        group_first;
    logic        group_last;
    logic        clear_phase;
  } req_t;

  // One result item
  typedef struct packed {
    res_kind_t   result_kind;
    logic [11:0] bus_address;
    logic [15:0] bus_data;
    logic        strobe_level;
    logic [2:0]  status;
    logic        last_result;
  } res_t;

endpackage

// ----- hw/rtl/dcld_fifo.sv -----
// Small first-word-fall-through queue of any packed type.
// Used between front and back and in front of the result port; no package needed.
module dcld_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/dcld_front.sv -----
// Front end: classifies input items and checks their index ranges.
// Depends on dcld_pkg; feeds the request queue towards dcld_back.
module dcld_front import dcld_pkg::*; #(
  parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
  parameter int PORT_DEPTH = PORT_DEPTH_DEF
) (
  input  logic [1:0]                   opcode,
  input  logic [5:0]                   index,
  input  logic [2:0]                   entry_kind,
  input  logic [3:0]                   port_select,
  input  logic [15:0]                  bit_mask,
  input  logic [15:0]                  data_value,
  input  logic [11:0]                  bus_addr_in,
  input  logic                         group_first,
  input  logic                         group_last,
  input  logic                         clear_phase,
  input  logic [6:0]                   command_count,
  output req_t                         req,
  output logic [$clog2(CMD_DEPTH)-1:0] last_line
);

  localparam int CAW  = $clog2(CMD_DEPTH);
  localparam int CNTW = ($clog2(CMD_DEPTH + 1) > 7) ? $clog2(CMD_DEPTH + 1) : 7;
  localparam int PCW  = ($clog2(PORT_DEPTH + 1) > 6) ? $clog2(PORT_DEPTH + 1) : 6;

  logic [CNTW-1:0] valid_cnt;

  // Live table size: the smaller of the register and the depth
  assign valid_cnt = (CNTW'(command_count) < CNTW'(CMD_DEPTH)) ?
                     CNTW'(command_count) : CNTW'(CMD_DEPTH);
  assign last_line = (valid_cnt == '0) ? '0 : CAW'(valid_cnt - 1'b1);

  always_comb begin
    req.index       = index;
    req.entry_kind  = entry_kind;
    req.port_select = port_select;
    req.bit_mask    = bit_mask;
    req.data_value  = data_value;
    req.bus_addr    = bus_addr_in;
    req.group_first = group_first;
    req.group_last  = group_last;
    req.clear_phase = clear_phase;
    case (opcode)
      OPC_LOAD_CMD: begin
        req.cls      = RQ_LOAD_CMD;
        req.in_range = CNTW'(index) < CNTW'(CMD_DEPTH);
      end
      OPC_LOAD_PORT: begin
        req.cls      = RQ_LOAD_PORT;
        req.in_range = PCW'(index) < PCW'(PORT_DEPTH);
      end
      OPC_EXEC: begin
        req.cls      = RQ_EXEC;
        req.in_range = CNTW'(index) < valid_cnt;
      end
      default: begin
        req.cls      = RQ_BAD_OP;
        req.in_range = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dcld_back.sv -----
// Back end: holds the command and port tables and carries out requests.
// Depends on dcld_pkg; takes requests from one dcld_fifo and fills another.
module dcld_back import dcld_pkg::*; #(
  parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
  parameter int PORT_DEPTH = PORT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   strobe_mode,
  input  logic [$clog2(CMD_DEPTH)-1:0] last_line,
  input  req_t                         req,
  input  logic                         req_empty,
  output logic                         req_pop,
  output res_t                         res,
  output logic                         res_push,
  input  logic                         res_full
);

  localparam int CAW = $clog2(CMD_DEPTH);
  localparam int PAW = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEM,
    S_LAST,
    S_RUN,
    S_WR
  } state_t;

  typedef enum logic [1:0] {
    OP_PORT,
    OP_SIG,
    OP_IO
  } op_code_t;

  typedef struct packed {
    op_code_t       code;
    logic [PAW-1:0] port;
    logic [15:0]    clr_bits;
    logic [15:0]    set_bits;
    logic           level;
    logic [2:0]     status;
  } op_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [PAW-1:0] port;
    logic [15:0]    mask;
    logic [15:0]    value;
  } cmd_entry_t;

  function automatic op_t port_op(logic [PAW-1:0] p, logic [15:0] c, logic [15:0] s);
    op_t o;
    o.code     = OP_PORT;
    o.port     = p;
    o.clr_bits = c;
    o.set_bits = s;
    o.level    = 1'b0;
    o.status   = STS_OK;
    return o;
  endfunction

  // Line port ops get their port and bits once the last table line is read
  function automatic op_t strobe_op(logic lvl, logic [2:0] st, logic [1:0] mode);
    op_t o;
    o.code     = (mode == SM_SIGNAL) ? OP_SIG : ((mode == SM_IO) ? OP_IO : OP_PORT);
    o.port     = '0;
    o.clr_bits = '0;
    o.set_bits = '0;
    o.level    = lvl;
    o.status   = st;
    return o;
  endfunction

  function automatic res_t status_res(logic [2:0] st);
    res_t r;
    r.result_kind  = RK_STATUS;
    r.bus_address  = '0;
    r.bus_data     = '0;
    r.strobe_level = 1'b0;
    r.status       = st;
    r.last_result  = 1'b1;
    return r;
  endfunction

  // Tables
  cmd_entry_t  cmd_mem_r  [CMD_DEPTH];
  logic [11:0] addr_mem_r [PORT_DEPTH];
  logic [15:0] sh_mem_r   [PORT_DEPTH];
  cmd_entry_t  cmd_rd_r;
  logic [11:0] addr_rd_r;
  logic [15:0] sh_rd_r;

  // Port wrap for loaded commands
  logic [PAW-1:0] port_wrap [PSEL_VALUES];
  for (genvar g = 0; g < PSEL_VALUES; g++) begin : g_wrap
    assign port_wrap[g] = PAW'(g % PORT_DEPTH);
  end

  state_t         state_r, state_nxt;
  req_t           cur_r, cur_nxt;
  op_t            op_r [2];
  op_t            op_nxt [2];
  logic           op_idx_r, op_idx_nxt;
  logic           op_last_r, op_last_nxt;
  logic           strb_slot_r, strb_slot_nxt;
  logic [5:0]     strobe_cmd_r, strobe_cmd_nxt;
  logic [2:0]     group_kind_r, group_kind_nxt;
  logic           aborted_r, aborted_nxt;

  logic           cmd_we, cmd_re;
  logic [CAW-1:0] cmd_raddr;
  logic           addr_we, sh_we, port_re;
  logic [PAW-1:0] port_waddr, port_raddr;
  logic [15:0]    sh_wdata;

  always_comb begin
    op_t         cur_op;
    logic [2:0]  t;
    logic        mismatch;
    logic        spare;
    logic        need_strb;
    logic [15:0] m;
    logic [15:0] ev;
    logic [PAW-1:0] p;
    logic [15:0] new_sh;

    state_nxt      = state_r;
    cur_nxt        = cur_r;
    op_nxt[0]      = op_r[0];
    op_nxt[1]      = op_r[1];
    op_idx_nxt     = op_idx_r;
    op_last_nxt    = op_last_r;
    strb_slot_nxt  = strb_slot_r;
    strobe_cmd_nxt = strobe_cmd_r;
    group_kind_nxt = group_kind_r;
    aborted_nxt    = aborted_r;
    req_pop        = 1'b0;
    res_push       = 1'b0;
    res            = status_res(STS_OK);
    cmd_we         = 1'b0;
    cmd_re         = 1'b0;
    cmd_raddr      = CAW'(req.index);
    addr_we        = 1'b0;
    sh_we          = 1'b0;
    port_re        = 1'b0;
    port_waddr     = PAW'(req.index);
    port_raddr     = op_r[op_idx_r].port;
    sh_wdata       = req.data_value;

    cur_op    = op_r[op_idx_r];
    t         = cmd_rd_r.kind;
    m         = cmd_rd_r.mask;
    ev        = cur_r.data_value;
    p         = cmd_rd_r.port;
    mismatch  = !cur_r.group_first && (t != group_kind_r);
    spare     = !(t inside {[CT_STEP:CT_SELECT]});
    need_strb = 1'b0;
    new_sh    = (sh_rd_r & ~cur_op.clr_bits) | cur_op.set_bits;

    case (state_r)
      S_IDLE: begin
        if (!req_empty && !res_full) begin
          req_pop = 1'b1;
          case (req.cls)
            RQ_LOAD_CMD: begin
              cmd_we   = req.in_range;
              res_push = 1'b1;
              res      = status_res(req.in_range ? STS_OK : STS_RANGE);
            end
            RQ_LOAD_PORT: begin
              addr_we  = req.in_range;
              sh_we    = req.in_range;
              res_push = 1'b1;
              res      = status_res(req.in_range ? STS_OK : STS_RANGE);
            end
            RQ_EXEC: begin
              if (!req.group_first && aborted_r) begin
                res_push = 1'b1;
                res      = status_res(STS_SKIPPED);
              end else if (!req.in_range) begin
                res_push    = 1'b1;
                res         = status_res(STS_RANGE);
                aborted_nxt = 1'b1;
              end else begin
                aborted_nxt = 1'b0;
                cmd_re      = 1'b1;
                cur_nxt     = req;
                state_nxt   = S_ELEM;
              end
            end
            default: begin
              res_push = 1'b1;
              res      = status_res(STS_UNKNOWN);
            end
          endcase
        end
      end

      S_ELEM: begin
        if (cur_r.group_first) begin
          group_kind_nxt = t;
        end
        if (mismatch || spare) begin
          if (!res_full) begin
            res_push    = 1'b1;
            res         = status_res(mismatch ? STS_MISMATCH : STS_UNKNOWN);
            aborted_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          op_last_nxt = 1'b0;
          case (t)
            CT_STEP: begin
              op_nxt[0]   = port_op(p, '0, m);
              op_nxt[1]   = port_op(p, m, '0);
              op_last_nxt = 1'b1;
            end
            CT_STRB: begin
              if (cur_r.group_first && cur_r.clear_phase) begin
                // Clear the strobe before the element's own write
                op_nxt[0]     = strobe_op(1'b0, (cur_r.index != strobe_cmd_r) ?
                                          STS_BAD_STROBE : STS_OK, strobe_mode);
                op_nxt[1]     = port_op(p, m, '0);
                op_last_nxt   = 1'b1;
                strb_slot_nxt = 1'b0;
                need_strb     = 1'b1;
              end else begin
                op_nxt[0] = cur_r.clear_phase ? port_op(p, m, '0) : port_op(p, '0, m);
                if (!cur_r.clear_phase && cur_r.group_last) begin
                  op_nxt[1]     = strobe_op(1'b1, STS_OK, strobe_mode);
                  op_last_nxt   = 1'b1;
                  strb_slot_nxt = 1'b1;
                  need_strb     = 1'b1;
                end
              end
              if (cur_r.group_first && !cur_r.clear_phase) begin
                strobe_cmd_nxt = cur_r.index;
              end
            end
            CT_UNSTRB: begin
              op_nxt[0] = port_op(p, m, m & cmd_rd_r.value);
            end
            CT_SET: begin
              if (m != '0) begin
                op_nxt[0] = (ev != '0) ? port_op(p, '0, m) : port_op(p, m, '0);
              end else begin
                op_nxt[0] = port_op(p, '0, ev);
              end
            end
            default: begin
              op_nxt[0] = port_op(p, m, m & ~ev);
            end
          endcase
          op_idx_nxt = 1'b0;
          if (need_strb && (strobe_mode != SM_SIGNAL) && (strobe_mode != SM_IO)) begin
            // Fetch the last table line for the strobe write
            cmd_re    = 1'b1;
            cmd_raddr = last_line;
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end

      S_LAST: begin
        op_nxt[strb_slot_r].port     = cmd_rd_r.port;
        op_nxt[strb_slot_r].clr_bits = op_r[strb_slot_r].level ? '0 : cmd_rd_r.mask;
        op_nxt[strb_slot_r].set_bits = op_r[strb_slot_r].level ? cmd_rd_r.mask : '0;
        state_nxt                    = S_RUN;
      end

      S_RUN: begin
        if (cur_op.code == OP_PORT) begin
          port_re   = 1'b1;
          state_nxt = S_WR;
        end else if (!res_full) begin
          res_push         = 1'b1;
          res.status       = cur_op.status;
          res.last_result  = (op_idx_r == op_last_r);
          if (cur_op.code == OP_SIG) begin
            res.result_kind  = RK_STROBE;
            res.strobe_level = cur_op.level;
          end else begin
            res.result_kind = RK_BUS_WRITE;
            res.bus_address = STROBE_IO_ADDR;
            res.bus_data    = cur_op.level ? STROBE_CODE_SET : STROBE_CODE_CLR;
          end
          if (op_idx_r == op_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            op_idx_nxt = 1'b1;
          end
        end
      end

      S_WR: begin
        if (!res_full) begin
          sh_we           = 1'b1;
          port_waddr      = cur_op.port;
          sh_wdata        = new_sh;
          res_push        = 1'b1;
          res.result_kind = RK_BUS_WRITE;
          res.bus_address = addr_rd_r;
          res.bus_data    = new_sh;
          res.status      = cur_op.status;
          res.last_result = (op_idx_r == op_last_r);
          if (op_idx_r == op_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            op_idx_nxt = 1'b1;
            state_nxt  = S_RUN;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_idx_r     <= 1'b0;
      op_last_r    <= 1'b0;
      strb_slot_r  <= 1'b0;
      strobe_cmd_r <= '0;
      group_kind_r <= '0;
      aborted_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_idx_r     <= op_idx_nxt;
      op_last_r    <= op_last_nxt;
      strb_slot_r  <= strb_slot_nxt;
      strobe_cmd_r <= strobe_cmd_nxt;
      group_kind_r <= group_kind_nxt;
      aborted_r    <= aborted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    op_r[0] <= op_nxt[0];
    op_r[1] <= op_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_mem_r[CAW'(req.index)] <= {req.entry_kind, port_wrap[req.port_select],
                                     req.bit_mask, req.data_value};
    end
    if (cmd_re) begin
      cmd_rd_r <= cmd_mem_r[cmd_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem_r[port_waddr] <= req.bus_addr;
    end
    if (sh_we) begin
      sh_mem_r[port_waddr] <= sh_wdata;
    end
    if (port_re) begin
      addr_rd_r <= addr_mem_r[port_raddr];
      sh_rd_r   <= sh_mem_r[port_raddr];
    end
  end

endmodule

// ----- hw/rtl/discrete_command_line_driver_top.sv -----
// Top level of the discrete command line driver: configuration registers and
// the front, request queue, back and result queue. Depends on dcld_pkg.
//
// Usage:
//   Input channel: drive the in_ fields and raise in_push; the item is taken
//   at a clock edge with in_push high and in_full low. Load items fill the
//   command and port tables, execute items run one command element.
//   Result channel: while out_empty is low the oldest result sits on the out_
//   ports; raise out_pop to take it. out_last_result marks the final result
//   of an item (every item gives one or two results).
//   Configuration: cfg_index 0 is the strobe mode, 1 the command count. A
//   write lands at an edge with cfg_valid and cfg_ready high; cfg_ready is
//   always high. Write only while the block is idle.
//   Timing: the back end works one request at a time. A load or status-only
//   item is done in the idle state; a type mismatch or spare type ends in the
//   element state. A writing element passes the element state, fetches the
//   last table line if a strobe write goes to a port, then for each write
//   reads the port shadow in the run state and writes it back in the write
//   state, or uses only the run state for a strobe signal or I/O write.
//   Reset: queues empty, strobe mode 0, command count 64, group state clear.
//   A stalled receiver fills the result queue, the back end holds, and
//   in_full rises once the request queue is full.
module discrete_command_line_driver_top import dcld_pkg::*; #(
  parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
  parameter int PORT_DEPTH = PORT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_index,
  input  logic [2:0]  in_entry_kind,
  input  logic [3:0]  in_port_select,
  input  logic [15:0] in_bit_mask,
  input  logic [15:0] in_data_value,
  input  logic [11:0] in_bus_addr_in,
  input  logic        in_group_first,
  input  logic        in_group_last,
  input  logic        in_clear_phase,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_result_kind,
  output logic [11:0] out_bus_address,
  output logic [15:0] out_bus_data,
  output logic        out_strobe_level,
  output logic [2:0]  out_status,
  output logic        out_last_result,
  // configuration port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [1:0]                   strobe_mode_r;
  logic [6:0]                   command_count_r;
  req_t                         front_req;
  req_t                         q_req;
  logic                         q_empty;
  logic                         q_pop;
  res_t                         back_res;
  logic                         back_push;
  logic                         res_full;
  res_t                         res_head;
  logic [$clog2(CMD_DEPTH)-1:0] last_line;

  // Configuration registers: take every write at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_mode_r   <= SM_SIGNAL;
      command_count_r <= COMMAND_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STROBE_MODE:   strobe_mode_r   <= cfg_data[1:0];
        CFG_COMMAND_COUNT: command_count_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Classify the incoming item
  dcld_front #(
    .CMD_DEPTH  (CMD_DEPTH),
    .PORT_DEPTH (PORT_DEPTH)
  ) u_front (
    .opcode        (in_opcode),
    .index         (in_index),
    .entry_kind    (in_entry_kind),
    .port_select   (in_port_select),
    .bit_mask      (in_bit_mask),
    .data_value    (in_data_value),
    .bus_addr_in   (in_bus_addr_in),
    .group_first   (in_group_first),
    .group_last    (in_group_last),
    .clear_phase   (in_clear_phase),
    .command_count (command_count_r),
    .req           (front_req),
    .last_line     (last_line)
  );

  // Hold classified requests until the back end is free
  dcld_fifo #(
    .T     (req_t),
    .DEPTH (REQ_Q_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_req),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_req),
    .empty (q_empty)
  );

  // Carry out loads and command elements
  dcld_back #(
    .CMD_DEPTH  (CMD_DEPTH),
    .PORT_DEPTH (PORT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .strobe_mode (strobe_mode_r),
    .last_line   (last_line),
    .req         (q_req),
    .req_empty   (q_empty),
    .req_pop     (q_pop),
    .res         (back_res),
    .res_push    (back_push),
    .res_full    (res_full)
  );

  // Park results until the receiver takes them
  dcld_fifo #(
    .T     (res_t),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_result_kind  = res_head.result_kind;
  assign out_bus_address  = res_head.bus_address;
  assign out_bus_data     = res_head.bus_data;
  assign out_strobe_level = res_head.strobe_level;
  assign out_status       = res_head.status;
  assign out_last_result  = res_head.last_result;

endmodule
